/* hdl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 64 + FRAC_BITS;          // width of num << FRAC_BITS
    localparam int RND_BIT   = (FRAC_BITS == 0) ? 0 : FRAC_BITS - 1;
    localparam int QUO_BITS  = 32;                      // quotient bits worked out one per stage

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // control and finished result of non-divide words, carried down the pipe
    typedef struct packed {
        logic        valid;
        t_op         op;
        logic        div0;
        logic        sat;
        logic [31:0] re;
        logic [31:0] im;
    } t_ctl;

    // one part of a quotient in flight
    typedef struct packed {
        logic        neg;
        logic        big;     // quotient is at least 2^32: saturates
        logic [31:0] dlo;     // dividend bits still to shift in, msb first
        logic [63:0] rem;
        logic [31:0] quo;
    } t_dlane;

    // {saturated, 32-bit two's complement value}
    function automatic logic [32:0] sat_pack(input logic neg, input logic [64:0] mag);
        logic [64:0] lim;
        logic [64:0] m;
        logic        s;
        lim = neg ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
        s   = mag > lim;
        m   = s ? lim : mag;
        return {s, neg ? (32'd0 - m[31:0]) : m[31:0]};
    endfunction

endpackage

`default_nettype wire

/* hdl/cau_if.sv */
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

`default_nettype wire

/* hdl/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, exact sums as sign/magnitude, then rounding of mul
// results, saturation of add/sub/mul results and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front
    import cau_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_a_re,
    input  wire logic signed [31:0] i_a_im,
    input  wire logic signed [31:0] i_b_re,
    input  wire logic signed [31:0] i_b_im,
    output t_ctl                    o_ctl,
    output logic [63:0]             o_den,
    output t_dlane                  o_lane_re,
    output t_dlane                  o_lane_im
);

    // stage 1
    logic               r1_valid, r1_div0;
    t_op                r1_op;
    logic signed [32:0] r1_s_re, r1_s_im;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_b0, r1_p_b1;
    t_op                n1_op;
    logic signed [32:0] n1_s_re, n1_s_im;

    // stage 2
    logic               r2_valid, r2_div0;
    t_op                r2_op;
    logic               r2_neg_re, r2_neg_im;
    logic [63:0]        r2_mag_re, r2_mag_im, r2_den;
    logic signed [65:0] n2_re, n2_im;
    logic [65:0]        n2_mre, n2_mim;
    logic [32:0]        n2_are, n2_aim;

    // stage 3
    t_ctl               r3_ctl;
    logic [63:0]        r3_den;
    t_dlane             r3_re, r3_im;
    t_ctl               n3_ctl;
    t_dlane             n3_re, n3_im;
    logic [32:0]        n3_pre, n3_pim;

    function automatic t_dlane div_setup(input logic neg, input logic [63:0] mag,
                                         input logic [63:0] den);
        t_dlane          l;
        logic [DIV_W-1:0] d;
        d      = DIV_W'(mag) << FRAC_BITS;
        l.neg  = neg;
        l.rem  = 64'(d[DIV_W-1:32]);
        l.big  = l.rem >= den;
        l.dlo  = d[31:0];
        l.quo  = '0;
        return l;
    endfunction

    function automatic logic [64:0] rnd_shift(input logic [63:0] mag);
        return 65'(mag >> FRAC_BITS) + ((FRAC_BITS == 0) ? 65'd0 : 65'(mag[RND_BIT]));
    endfunction

    always_comb begin
        n1_op   = t_op'(i_req_type);
        n1_s_re = (n1_op == OP_SUB) ? 33'(i_a_re) - 33'(i_b_re) : 33'(i_a_re) + 33'(i_b_re);
        n1_s_im = (n1_op == OP_SUB) ? 33'(i_a_im) - 33'(i_b_im) : 33'(i_a_im) + 33'(i_b_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_op   <= n1_op;
            r1_div0 <= (n1_op == OP_DIV) && (i_b_re == 32'sd0) && (i_b_im == 32'sd0);
            r1_s_re <= n1_s_re;
            r1_s_im <= n1_s_im;
            r1_p_rr <= 64'(i_a_re) * 64'(i_b_re);
            r1_p_ii <= 64'(i_a_im) * 64'(i_b_im);
            r1_p_ri <= 64'(i_a_re) * 64'(i_b_im);
            r1_p_ir <= 64'(i_a_im) * 64'(i_b_re);
            r1_p_b0 <= 64'(i_b_re) * 64'(i_b_re);
            r1_p_b1 <= 64'(i_b_im) * 64'(i_b_im);
        end
    end

    always_comb begin
        n2_re  = (r1_op == OP_MUL) ? 66'(r1_p_rr) - 66'(r1_p_ii) : 66'(r1_p_rr) + 66'(r1_p_ii);
        n2_im  = (r1_op == OP_MUL) ? 66'(r1_p_ri) + 66'(r1_p_ir) : 66'(r1_p_ir) - 66'(r1_p_ri);
        n2_mre = n2_re[65] ? 66'(-n2_re) : 66'(n2_re);
        n2_mim = n2_im[65] ? 66'(-n2_im) : 66'(n2_im);
        n2_are = r1_s_re[32] ? 33'(-r1_s_re) : 33'(r1_s_re);
        n2_aim = r1_s_im[32] ? 33'(-r1_s_im) : 33'(r1_s_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_op   <= r1_op;
            r2_div0 <= r1_div0;
            r2_den  <= 64'($unsigned(r1_p_b0)) + 64'($unsigned(r1_p_b1));
            if (r1_op == OP_ADD || r1_op == OP_SUB) begin
                r2_neg_re <= r1_s_re[32];
                r2_neg_im <= r1_s_im[32];
                r2_mag_re <= 64'(n2_are);
                r2_mag_im <= 64'(n2_aim);
            end else begin
                r2_neg_re <= n2_re[65];
                r2_neg_im <= n2_im[65];
                r2_mag_re <= n2_mre[63:0];
                r2_mag_im <= n2_mim[63:0];
            end
        end
    end

    always_comb begin
        if (r2_op == OP_MUL) begin
            n3_pre = sat_pack(r2_neg_re, rnd_shift(r2_mag_re));
            n3_pim = sat_pack(r2_neg_im, rnd_shift(r2_mag_im));
        end else begin
            n3_pre = sat_pack(r2_neg_re, 65'(r2_mag_re));
            n3_pim = sat_pack(r2_neg_im, 65'(r2_mag_im));
        end
        n3_ctl.valid = r2_valid;
        n3_ctl.op    = r2_op;
        n3_ctl.div0  = r2_div0;
        n3_ctl.sat   = n3_pre[32] | n3_pim[32];
        n3_ctl.re    = n3_pre[31:0];
        n3_ctl.im    = n3_pim[31:0];
        n3_re        = div_setup(r2_neg_re, r2_mag_re, r2_den);
        n3_im        = div_setup(r2_neg_im, r2_mag_im, r2_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r3_ctl.valid <= n3_ctl.valid;
        end
        if (i_en) begin
            r3_ctl.op   <= n3_ctl.op;
            r3_ctl.div0 <= n3_ctl.div0;
            r3_ctl.sat  <= n3_ctl.sat;
            r3_ctl.re   <= n3_ctl.re;
            r3_ctl.im   <= n3_ctl.im;
            r3_den      <= r2_den;
            r3_re       <= n3_re;
            r3_im       <= n3_im;
        end
    end

    assign o_ctl     = r3_ctl;
    assign o_den     = r3_den;
    assign o_lane_re = r3_re;
    assign o_lane_im = r3_im;

endmodule

`default_nettype wire

/* hdl/cau_div_step.sv */
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step for both quotient parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step
    import cau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_ctl        i_ctl,
    input  wire logic [63:0] i_den,
    input  wire t_dlane      i_re,
    input  wire t_dlane      i_im,
    output t_ctl             o_ctl,
    output logic [63:0]      o_den,
    output t_dlane           o_re,
    output t_dlane           o_im
);

    t_ctl        r_ctl;
    logic [63:0] r_den;
    t_dlane      r_re, r_im;

    function automatic t_dlane step(input t_dlane l, input logic [63:0] den);
        t_dlane      o;
        logic [64:0] t;
        logic        ge;
        t     = {l.rem, l.dlo[31]};
        ge    = t >= {1'b0, den};
        o     = l;
        o.rem = ge ? 64'(t - {1'b0, den}) : t[63:0];
        o.quo = {l.quo[30:0], ge};
        o.dlo = {l.dlo[30:0], 1'b0};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op   <= i_ctl.op;
            r_ctl.div0 <= i_ctl.div0;
            r_ctl.sat  <= i_ctl.sat;
            r_ctl.re   <= i_ctl.re;
            r_ctl.im   <= i_ctl.im;
            r_den      <= i_den;
            r_re       <= step(i_re, i_den);
            r_im       <= step(i_im, i_den);
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_re  = r_re;
    assign o_im  = r_im;

endmodule

`default_nettype wire

/* hdl/complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add/sub/mul/div in signed Q16.16.
// ----------------------------------------------------------------------------
// Request channel i_req carries req_type and operands a, b; result channel
// o_rsp carries res_re, res_im and status (ok, divide by zero, saturated).
// Both use valid/ready; a word moves when both are high.
// Every word, of any operation, passes all stages from acceptance to result
// valid: 3 front stages (products, sums, round/setup), 32 division steps
// (one quotient bit per stage) and the output register. Unless stalled, a new
// word is accepted every cycle. The pipeline advances as a whole when the
// output register is empty or being taken; when the receiver stalls with a
// result waiting, i_req.ready drops and every stage holds its word, so nothing
// is lost or repeated. Reset clears all valid bits; the first word can be
// accepted in the cycle after reset is released. Results come out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit
    import cau_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cau_req_if.sink   i_req,
    cau_rsp_if.source o_rsp
);

    logic        w_en;
    t_ctl        w_ctl  [QUO_BITS+1];
    logic [63:0] w_den  [QUO_BITS+1];
    t_dlane      w_re   [QUO_BITS+1];
    t_dlane      w_im   [QUO_BITS+1];

    logic        r_valid;
    logic [31:0] r_res_re, r_res_im;
    logic [1:0]  r_status;

    t_ctl        n_ctl;
    logic [32:0] n_pre, n_pim;

    assign w_en        = !r_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    cau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_a_re     (i_req.a_re),
        .i_a_im     (i_req.a_im),
        .i_b_re     (i_req.b_re),
        .i_b_im     (i_req.b_im),
        .o_ctl      (w_ctl[0]),
        .o_den      (w_den[0]),
        .o_lane_re  (w_re[0]),
        .o_lane_im  (w_im[0])
    );

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_den   (w_den[k]),
            .i_re    (w_re[k]),
            .i_im    (w_im[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_den   (w_den[k+1]),
            .o_re    (w_re[k+1]),
            .o_im    (w_im[k+1])
        );
    end

    // round half away from zero: bump when 2*rem >= den
    function automatic logic [32:0] quo_final(input t_dlane l, input logic [63:0] den);
        logic [64:0] q;
        q = 65'(l.quo) + 65'({l.rem, 1'b0} >= {1'b0, den});
        if (l.big) begin
            q = 65'h1_0000_0000;
        end
        return sat_pack(l.neg, q);
    endfunction

    always_comb begin
        n_ctl = w_ctl[QUO_BITS];
        n_pre = quo_final(w_re[QUO_BITS], w_den[QUO_BITS]);
        n_pim = quo_final(w_im[QUO_BITS], w_den[QUO_BITS]);
        if (n_ctl.op == OP_DIV) begin
            n_ctl.sat = n_pre[32] | n_pim[32];
            n_ctl.re  = n_pre[31:0];
            n_ctl.im  = n_pim[31:0];
        end
        if (n_ctl.div0) begin
            n_ctl.sat = 1'b0;
            n_ctl.re  = '0;
            n_ctl.im  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= n_ctl.valid;
        end
        if (w_en) begin
            r_res_re <= n_ctl.re;
            r_res_im <= n_ctl.im;
            r_status <= n_ctl.div0 ? ST_DIV0 : (n_ctl.sat ? ST_SAT : ST_OK);
        end
    end

    assign o_rsp.valid  = r_valid;
    assign o_rsp.res_re = r_res_re;
    assign o_rsp.res_im = r_res_im;
    assign o_rsp.status = r_status;

endmodule

`default_nettype wire
